// ----- rtl/core/chc_pkg.sv -----
`default_nettype none
package chc_pkg;
  localparam int DataW = 16;
  localparam int HeadW = 9;
  localparam int CntW = 8;
  localparam int ThrW = 15;
  localparam int AccW = 26;   // angle in degrees, 16 fraction bits, signed headroom
  localparam int MaxSteps = 24;
  localparam logic [AccW-1:0] Deg180 = AccW'(180 * 65536);
  localparam logic [AccW-1:0] Deg360 = AccW'(360 * 65536);

  localparam logic [0:0] CfgCalSamples = 1'b0;
  localparam logic [0:0] CfgLevelThr = 1'b1;

  // atan(2^-i) in degrees, Q16, rounded to nearest
  function automatic logic [21:0] atan_q16(input logic [4:0] i);
    logic [21:0] r;
    begin
      case (i)
        5'd0: r = 22'd2949120; 5'd1: r = 22'd1740967; 5'd2: r = 22'd919879;
        5'd3: r = 22'd466945;  5'd4: r = 22'd234379;  5'd5: r = 22'd117304;
        5'd6: r = 22'd58666;   5'd7: r = 22'd29335;   5'd8: r = 22'd14668;
        5'd9: r = 22'd7334;    5'd10: r = 22'd3667;   5'd11: r = 22'd1833;
        5'd12: r = 22'd917;    5'd13: r = 22'd458;    5'd14: r = 22'd229;
        5'd15: r = 22'd115;    5'd16: r = 22'd57;     5'd17: r = 22'd29;
        5'd18: r = 22'd14;     5'd19: r = 22'd7;      5'd20: r = 22'd4;
        5'd21: r = 22'd2;      5'd22: r = 22'd1;
        default: r = 22'd0;
      endcase
      return r;
    end
  endfunction
endpackage
`default_nettype wire

// ----- rtl/core/chc_if.sv -----
`default_nettype none
interface chc_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] mag_x;
  logic signed [15:0] mag_y;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  modport source (output valid, mag_x, mag_y, accel_x, accel_y, input ready);
  modport sink (input valid, mag_x, mag_y, accel_x, accel_y, output ready);
endinterface

interface chc_out_if;
  logic valid;
  logic ready;
  logic calibrating;
  logic [7:0] samples_seen;
  logic [8:0] heading_deg;
  logic is_level;
  modport source (output valid, calibrating, samples_seen, heading_deg, is_level,
                  input ready);
  modport sink (input valid, calibrating, samples_seen, heading_deg, is_level,
                output ready);
endinterface
`default_nettype wire

// ----- rtl/core/chc_mul.sv -----
`default_nettype none
// Serial shift-add multiplier: unsigned magnitude, one multiplier bit per cycle.
module chc_mul #(
  parameter int AW = 18,
  parameter int BW = 17
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [AW-1:0] a,
  input  wire logic [BW-1:0] b,
  output logic               done,
  output logic [AW+BW-1:0]   prod
);
  localparam int CW = $clog2(BW + 1);
  logic [AW+BW-1:0] acc_r, acc_nxt;
  logic [AW+BW-1:0] a_r, a_nxt;
  logic [BW-1:0]    b_r, b_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  always_comb begin
    acc_nxt = acc_r; a_nxt = a_r; b_nxt = b_r; cnt_nxt = cnt_r; busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt = '0; a_nxt = (AW+BW)'(a); b_nxt = b; cnt_nxt = '0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (b_r[0]) acc_nxt = acc_r + a_r;
      a_nxt = a_r << 1;
      b_nxt = b_r >> 1;
      cnt_nxt = cnt_r + 1'b1;
      // last bit: flag done once the final partial sum is in acc_r
      if (cnt_r == CW'(BW - 1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end
  assign done = done_r;
  assign prod = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; cnt_r <= '0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; cnt_r <= cnt_nxt; done_r <= done_nxt;
    end
    acc_r <= acc_nxt; a_r <= a_nxt; b_r <= b_nxt;
  end
endmodule
`default_nettype wire

// ----- rtl/core/chc_cordic.sv -----
`default_nettype none
// Iterative vectoring CORDIC, one micro-rotation per cycle, output in whole degrees.
module chc_cordic #(
  parameter int Steps = 16,
  parameter int VW = 56
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic signed [VW-1:0] x_in,
  input  wire logic signed [VW-1:0] y_in,
  output logic                      done,
  output logic [chc_pkg::HeadW-1:0] deg
);
  localparam int SW = $clog2(Steps + 1);
  localparam int AW = chc_pkg::AccW;
  logic signed [VW-1:0] x_r, x_nxt, y_r, y_nxt, xs, ys;
  logic signed [AW-1:0] z_r, z_nxt, za;
  logic [SW-1:0] i_r, i_nxt;
  logic busy_r, busy_nxt, fin_r, fin_nxt;
  logic [AW-1:0] zw;

  always_comb begin
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; i_nxt = i_r; busy_nxt = busy_r;
    fin_nxt = 1'b0;
    xs = x_r >>> i_r;
    ys = y_r >>> i_r;
    za = AW'($signed({1'b0, chc_pkg::atan_q16(5'(i_r))}));
    if (start) begin
      // fold left half-plane first
      if (x_in < 0) begin
        x_nxt = -x_in; y_nxt = -y_in; z_nxt = chc_pkg::Deg180;
      end else begin
        x_nxt = x_in; y_nxt = y_in; z_nxt = '0;
      end
      i_nxt = '0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (y_r >= 0) begin
        x_nxt = x_r + ys; y_nxt = y_r - xs; z_nxt = z_r + za;
      end else begin
        x_nxt = x_r - ys; y_nxt = y_r + xs; z_nxt = z_r - za;
      end
      i_nxt = i_r + 1'b1;
      if (i_r == SW'(Steps - 1)) begin
        busy_nxt = 1'b0; fin_nxt = 1'b1;
      end
    end
    // wrap into [0,360)
    if (z_r < 0) zw = z_r + chc_pkg::Deg360;
    else if (z_r >= $signed(chc_pkg::Deg360)) zw = z_r - chc_pkg::Deg360;
    else zw = z_r;
  end
  assign done = fin_r;
  assign deg = zw[16 +: chc_pkg::HeadW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; fin_r <= 1'b0; i_r <= '0;
    end else begin
      busy_r <= busy_nxt; fin_r <= fin_nxt; i_r <= i_nxt;
    end
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt;
  end
endmodule
`default_nettype wire

// ----- rtl/core/compass_heading_calibrated_unit.sv -----
`default_nettype none
// Compass heading unit with hard-iron calibration. Each accepted word gives one
// result word, and one word is in flight at a time: the input is ready only while
// the sequencer is idle and the result register is empty. The first cal_samples
// words update the per-axis min/max and load their result at the accepting edge,
// so such words skip the sequencer. A later word whose corrected vector is zero
// repeats the last heading, loaded through S_PREP and S_OUT. Any other word runs
// two serial 18x17 multiplies side by side (one bit per cycle) and then
// CORDIC_STEPS iterations of a single CORDIC micro-rotation unit; its result is
// loaded from S_OUT once the CORDIC is done. The next word is taken only after
// the result register has been emptied.
module compass_heading_calibrated_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  chc_in_if.sink          in_ch,
  chc_out_if.source       out_ch,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [14:0] cfg_data
);
  localparam int DW = chc_pkg::DataW;
  localparam int PW = 35;   // 18-bit magnitude times 17-bit range
  localparam int VW = PW + 1 + 16 + 3;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_PREP = 5'b00010, S_MUL = 5'b00100,
    S_CORD = 5'b01000, S_OUT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [7:0]  cal_r;
  logic [14:0] thr_r;
  logic signed [DW-1:0] xmax_r, xmin_r, ymax_r, ymin_r;
  logic [7:0]  cnt_r;
  logic [8:0]  last_r;
  logic signed [DW-1:0] mx_r, my_r;
  logic lvl_r;
  logic o_valid_r, o_cal_r, o_lvl_r;
  logic [7:0] o_seen_r;
  logic [8:0] o_head_r;
  logic sx_r, sy_r;
  logic mul_start, mx_done, my_done, cd_start, cd_done;
  logic [PW-1:0] px, py;
  logic [8:0] cd_deg;
  logic signed [VW-1:0] vx, vy;
  logic signed [DW:0] ax_ext, ay_ext, thr_ext;
  logic in_cal, in_acc;
  logic [16:0] rxw, ryw, rxs, rys;
  logic signed [17:0] dx2w, dy2w;
  logic [17:0] dx2m, dy2m;

  assign in_ch.ready = (state_r == S_IDLE) && !o_valid_r;
  assign in_acc = in_ch.valid && in_ch.ready;
  assign out_ch.valid = o_valid_r;
  assign out_ch.calibrating = o_cal_r;
  assign out_ch.samples_seen = o_seen_r;
  assign out_ch.heading_deg = o_head_r;
  assign out_ch.is_level = o_lvl_r;

  // level check on the incoming word
  assign ax_ext = (DW+1)'(in_ch.accel_x);
  assign ay_ext = (DW+1)'(in_ch.accel_y);
  assign thr_ext = $signed({2'b00, thr_r});
  assign in_cal = cnt_r < cal_r;

  // offset and range from the stored extremes
  assign rxw = 17'(18'(xmax_r) - 18'(xmin_r));
  assign ryw = 17'(18'(ymax_r) - 18'(ymin_r));
  assign dx2w = 18'({mx_r[DW-1], mx_r, 1'b0}) - (18'(xmax_r) + 18'(xmin_r));
  assign dy2w = 18'({my_r[DW-1], my_r, 1'b0}) - (18'(ymax_r) + 18'(ymin_r));

  // multiplier operands: magnitudes, a zero range replaced by 2
  assign dx2m = dx2w[17] ? 18'(-dx2w) : 18'(dx2w);
  assign dy2m = dy2w[17] ? 18'(-dy2w) : 18'(dy2w);
  assign rxs = (rxw == '0) ? 17'd2 : rxw;
  assign rys = (ryw == '0) ? 17'd2 : ryw;

  assign mul_start = (state_r == S_PREP);
  chc_mul #(.AW(18), .BW(17)) u_mul_x (
    .clk(clk), .rst_n(rst_n), .start(mul_start),
    .a(dx2m), .b(rys), .done(mx_done), .prod(px)
  );
  chc_mul #(.AW(18), .BW(17)) u_mul_y (
    .clk(clk), .rst_n(rst_n), .start(mul_start),
    .a(dy2m), .b(rxs), .done(my_done), .prod(py)
  );

  // X = dx2*ry, Y = -dy2*rx, both scaled by 2^16
  assign vx = sx_r ? -$signed({(VW-PW-16)'(0), px, 16'd0})
                   : $signed({(VW-PW-16)'(0), px, 16'd0});
  assign vy = sy_r ? $signed({(VW-PW-16)'(0), py, 16'd0})
                   : -$signed({(VW-PW-16)'(0), py, 16'd0});
  assign cd_start = (state_r == S_MUL) && mx_done && my_done;

  chc_cordic #(.Steps(CORDIC_STEPS), .VW(VW)) u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cd_start), .x_in(vx), .y_in(vy),
    .done(cd_done), .deg(cd_deg)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc && !in_cal) state_nxt = S_PREP;
      S_PREP: begin
        if (dx2w == '0 && dy2w == '0) state_nxt = S_OUT;
        else state_nxt = S_MUL;
      end
      S_MUL:  if (mx_done && my_done) state_nxt = S_CORD;
      S_CORD: if (cd_done) state_nxt = S_OUT;
      S_OUT:  if (!o_valid_r || out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cal_r <= 8'd200; thr_r <= 15'd100;
      xmax_r <= '0; xmin_r <= '0; ymax_r <= '0; ymin_r <= '0;
      cnt_r <= '0; last_r <= '0; o_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          chc_pkg::CfgCalSamples: cal_r <= cfg_data[7:0];
          chc_pkg::CfgLevelThr:   thr_r <= cfg_data;
          default: ;
        endcase
      end
      // result valid: loaded by either path, cleared when taken
      if (state_r == S_OUT && (!o_valid_r || out_ch.ready)) begin
        o_valid_r <= 1'b1;
      end else if (in_acc && in_cal) begin
        o_valid_r <= 1'b1;
      end else if (o_valid_r && out_ch.ready) begin
        o_valid_r <= 1'b0;
      end
      if (in_acc) begin
        mx_r <= in_ch.mag_x; my_r <= in_ch.mag_y;
        lvl_r <= (ax_ext < thr_ext) && (ax_ext > -thr_ext) &&
                 (ay_ext < thr_ext) && (ay_ext > -thr_ext);
        if (in_cal) begin
          if (in_ch.mag_x > xmax_r) xmax_r <= in_ch.mag_x;
          if (in_ch.mag_x < xmin_r) xmin_r <= in_ch.mag_x;
          if (in_ch.mag_y > ymax_r) ymax_r <= in_ch.mag_y;
          if (in_ch.mag_y < ymin_r) ymin_r <= in_ch.mag_y;
          cnt_r <= cnt_r + 8'd1;
          // result goes straight to the (empty) output register
          o_cal_r <= 1'b1; o_head_r <= '0;
          o_seen_r <= (cnt_r + 8'd1 < cal_r) ? cnt_r + 8'd1 : cal_r;
          o_lvl_r <= (ax_ext < thr_ext) && (ax_ext > -thr_ext) &&
                     (ay_ext < thr_ext) && (ay_ext > -thr_ext);
        end
      end
      if (state_r == S_PREP) begin
        sx_r <= dx2w[17]; sy_r <= dy2w[17];
      end
      if (state_r == S_CORD && cd_done) last_r <= cd_deg;
      if (state_r == S_OUT && (!o_valid_r || out_ch.ready)) begin
        o_cal_r <= 1'b0; o_head_r <= last_r;
        o_seen_r <= (cnt_r < cal_r) ? cnt_r : cal_r;
        o_lvl_r <= lvl_r;
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cd_start |-> state_r == S_MUL) else $error("cordic started outside multiply");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |=> (state_r == S_OUT || state_r == S_IDLE))
    else $error("bad exit from output state");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid)
    else $error("input taken while a result is pending");
endmodule
`default_nettype wire
